FILE: sv/tle_pkg.sv
// tle_pkg: shared types and constants of the terminal line editor
// holds command classes, result action codes, register indexes and reset values
// no dependencies
package tle_pkg;

    localparam int KEY_W = 8;
    localparam int LEN_W = 7;
    localparam int ACT_W = 3;
    localparam int CFG_IDX_W = 2;

    // result action codes
    localparam logic [ACT_W-1:0] ACT_ECHO    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RUBOUT  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_NEWLINE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BELL    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_END     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EOF        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_ERASE = 2'd3;

    // register reset values
    localparam logic [KEY_W-1:0] EOF_RST        = 8'd4;
    localparam logic [KEY_W-1:0] ERASE_RST      = 8'd127;
    localparam logic [KEY_W-1:0] KILL_RST       = 8'd21;
    localparam logic [KEY_W-1:0] WORD_ERASE_RST = 8'd23;

    // printable range and the space character
    localparam logic [KEY_W-1:0] KEY_SPACE    = 8'd32;
    localparam logic [KEY_W-1:0] PRINTABLE_LO = 8'd32;
    localparam logic [KEY_W-1:0] PRINTABLE_HI = 8'd126;

    typedef enum logic [2:0] {
        CMD_ERASE,
        CMD_KILL,
        CMD_WORD_ERASE,
        CMD_PRINT,
        CMD_BELL
    } t_cmd;

    // one classified key, as it travels from front to back
    typedef struct packed {
        logic             eof_hit;
        t_cmd             cmd;
        logic [KEY_W-1:0] key;
    } t_entry;

endpackage

FILE: sv/tle_front.sv
// tle_front: control code registers and key classification
// depends on tle_pkg
module tle_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tle_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tle_pkg::KEY_W-1:0]       i_cfg_data,
    input  logic [tle_pkg::KEY_W-1:0]       i_key_byte,
    output tle_pkg::t_entry                 o_entry
);

    logic [tle_pkg::KEY_W-1:0] r_eof_code;
    logic [tle_pkg::KEY_W-1:0] r_erase_code;
    logic [tle_pkg::KEY_W-1:0] r_kill_code;
    logic [tle_pkg::KEY_W-1:0] r_word_erase_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eof_code        <= tle_pkg::EOF_RST;
            r_erase_code      <= tle_pkg::ERASE_RST;
            r_kill_code       <= tle_pkg::KILL_RST;
            r_word_erase_code <= tle_pkg::WORD_ERASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tle_pkg::CFG_EOF:        r_eof_code        <= i_cfg_data;
                tle_pkg::CFG_ERASE:      r_erase_code      <= i_cfg_data;
                tle_pkg::CFG_KILL:       r_kill_code       <= i_cfg_data;
                tle_pkg::CFG_WORD_ERASE: r_word_erase_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // priority order: erase, kill, word erase, printable, bell
    // end of input depends on the line length, so back decides it
    always_comb begin
        o_entry.key     = i_key_byte;
        o_entry.eof_hit = (i_key_byte == r_eof_code);
        if (i_key_byte == r_erase_code) begin
            o_entry.cmd = tle_pkg::CMD_ERASE;
        end else if (i_key_byte == r_kill_code) begin
            o_entry.cmd = tle_pkg::CMD_KILL;
        end else if (i_key_byte == r_word_erase_code) begin
            o_entry.cmd = tle_pkg::CMD_WORD_ERASE;
        end else if (i_key_byte >= tle_pkg::PRINTABLE_LO &&
                     i_key_byte <= tle_pkg::PRINTABLE_HI) begin
            o_entry.cmd = tle_pkg::CMD_PRINT;
        end else begin
            o_entry.cmd = tle_pkg::CMD_BELL;
        end
    end

endmodule

FILE: sv/tle_queue.sv
// tle_queue: two-entry queue of classified keys between front and back
// depends on tle_pkg
module tle_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tle_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output tle_pkg::t_entry o_entry
);

    tle_pkg::t_entry r_slot [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_slot[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/tle_back.sv
// tle_back: line state, space-mark memory and result sequencer
// depends on tle_pkg
module tle_back #(
    parameter int LINE_CAPACITY = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  tle_pkg::t_entry             i_q_entry,
    output logic                        o_q_pop,
    input  logic                        i_res_stall,
    output logic                        o_res_valid,
    output logic [tle_pkg::ACT_W-1:0]   o_action,
    output logic [tle_pkg::KEY_W-1:0]   o_echo_char,
    output logic                        o_last_of_run
);

    localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
    localparam logic [tle_pkg::LEN_W-1:0] CAP_L = tle_pkg::LEN_W'(LINE_CAPACITY);
    localparam logic [tle_pkg::LEN_W-1:0] LEN_ONE = tle_pkg::LEN_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_KILL,
        S_WLOAD,
        S_WSPACE,
        S_WWORD,
        S_PRINT
    } t_state;

    t_state                      r_state, n_state;
    logic [tle_pkg::LEN_W-1:0]   r_len, n_len;
    logic                        r_fin, n_fin;
    tle_pkg::t_entry             r_cur, n_cur;
    logic                        r_top, n_top;
    logic                        r_rd;
    logic                        r_marks [LINE_CAPACITY];
    logic                        r_res_valid, n_res_valid;
    logic [tle_pkg::ACT_W-1:0]   r_action;
    logic [tle_pkg::KEY_W-1:0]   r_echo;
    logic                        r_last;

    logic                        w_emit_ok;
    logic                        w_emit;
    logic [tle_pkg::ACT_W-1:0]   w_act;
    logic [tle_pkg::KEY_W-1:0]   w_chr;
    logic                        w_last;
    logic                        w_we;
    logic [AW-1:0]               w_rd_addr;
    logic [tle_pkg::LEN_W-1:0]   w_len_m1;
    logic [tle_pkg::LEN_W-1:0]   w_len_m2;
    logic [tle_pkg::LEN_W-1:0]   w_len_m3;

    assign w_emit_ok = !r_res_valid || !i_res_stall;
    assign w_len_m1  = r_len - tle_pkg::LEN_W'(1);
    assign w_len_m2  = r_len - tle_pkg::LEN_W'(2);
    assign w_len_m3  = r_len - tle_pkg::LEN_W'(3);
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;

    // in the word erase states r_top is the mark at len-1 and r_rd the mark at len-2
    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_fin     = r_fin;
        n_cur     = r_cur;
        n_top     = r_top;
        w_emit    = 1'b0;
        w_act     = tle_pkg::ACT_BELL;
        w_chr     = '0;
        w_last    = 1'b1;
        w_we      = 1'b0;
        w_rd_addr = w_len_m2[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_cur   = i_q_entry;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                w_rd_addr = w_len_m1[AW-1:0];
                if (r_fin) begin
                    n_state = S_IDLE;
                end else if (r_cur.eof_hit && r_len == '0) begin
                    if (w_emit_ok) begin
                        w_emit  = 1'b1;
                        w_act   = tle_pkg::ACT_END;
                        n_fin   = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    case (r_cur.cmd)
                        tle_pkg::CMD_ERASE: begin
                            if (r_len == '0) begin
                                n_state = S_IDLE;
                            end else if (w_emit_ok) begin
                                w_emit  = 1'b1;
                                w_act   = tle_pkg::ACT_RUBOUT;
                                n_len   = w_len_m1;
                                n_state = S_IDLE;
                            end
                        end
                        tle_pkg::CMD_KILL: begin
                            n_state = (r_len == '0) ? S_IDLE : S_KILL;
                        end
                        tle_pkg::CMD_WORD_ERASE: begin
                            n_state = (r_len == '0) ? S_IDLE : S_WLOAD;
                        end
                        tle_pkg::CMD_PRINT: begin
                            n_state = S_PRINT;
                        end
                        tle_pkg::CMD_BELL: begin
                            if (w_emit_ok) begin
                                w_emit  = 1'b1;
                                w_act   = tle_pkg::ACT_BELL;
                                n_state = S_IDLE;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_KILL: begin
                if (w_emit_ok) begin
                    w_emit = 1'b1;
                    w_act  = tle_pkg::ACT_RUBOUT;
                    w_last = (r_len == LEN_ONE);
                    n_len  = w_len_m1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WLOAD: begin
                n_top   = r_rd;
                n_state = S_WSPACE;
            end
            S_WSPACE: begin
                if (!r_top) begin
                    n_state = S_WWORD;
                end else if (w_emit_ok) begin
                    w_emit    = 1'b1;
                    w_act     = tle_pkg::ACT_RUBOUT;
                    w_last    = (r_len == LEN_ONE);
                    n_len     = w_len_m1;
                    n_top     = r_rd;
                    w_rd_addr = w_len_m3[AW-1:0];
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WWORD: begin
                if (w_emit_ok) begin
                    w_emit    = 1'b1;
                    w_act     = tle_pkg::ACT_RUBOUT;
                    // stop at start of line or when a space lies below
                    w_last    = (r_len == LEN_ONE) ? 1'b1 : r_rd;
                    n_len     = w_len_m1;
                    n_top     = r_rd;
                    w_rd_addr = w_len_m3[AW-1:0];
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PRINT: begin
                if (w_emit_ok) begin
                    w_emit = 1'b1;
                    if (r_len >= CAP_L) begin
                        w_act  = tle_pkg::ACT_NEWLINE;
                        w_last = 1'b0;
                        n_len  = '0;
                    end else begin
                        w_act   = tle_pkg::ACT_ECHO;
                        w_chr   = r_cur.key;
                        w_we    = 1'b1;
                        n_len   = r_len + tle_pkg::LEN_W'(1);
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (w_emit) begin
            n_res_valid = 1'b1;
        end else if (i_res_stall) begin
            n_res_valid = r_res_valid;
        end else begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_marks[r_len[AW-1:0]] <= (r_cur.key == tle_pkg::KEY_SPACE);
        end
        r_rd <= r_marks[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_fin       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_fin       <= n_fin;
            r_res_valid <= n_res_valid;
        end
        r_cur <= n_cur;
        r_top <= n_top;
        if (w_emit) begin
            r_action <= w_act;
            r_echo   <= w_chr;
            r_last   <= w_last;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_action      = r_action;
    assign o_echo_char   = r_echo;
    assign o_last_of_run = r_last;

endmodule

FILE: sv/terminal_line_editor_core.sv
// terminal_line_editor_core: canonical line editing on a stream of key bytes
// depends on tle_pkg, tle_front, tle_queue, tle_back
//
// key channel: one byte per transfer on i_key_byte (i_key_valid / o_key_stall)
// result channel: action, echo_char, last_of_run (o_res_valid / i_res_stall);
//   a key gives zero or more results, the final one carries last_of_run
// config: i_cfg_we writes i_cfg_data to the code chosen by i_cfg_index
//   (0 end of input, 1 erase, 2 kill, 3 word erase); the user must write
//   only while idle, as the block does not enforce it
// keys: the back takes one key from the queue at a time, only when idle,
//   and ends all its results before it takes the next; the two-entry key
//   queue lets keys arrive meanwhile
// stall: results wait in the output register; the sequencer freezes and
//   the queue fills, then o_key_stall rises
// reset: synchronous, active low; codes return to 4, 127, 21, 23, line empty,
//   session open; after end of input all keys are dropped until reset
module terminal_line_editor_core #(
    parameter int LINE_CAPACITY = 40
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [tle_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tle_pkg::KEY_W-1:0]       i_cfg_data,
    // key input channel
    input  logic                            i_key_valid,
    output logic                            o_key_stall,
    input  logic [tle_pkg::KEY_W-1:0]       i_key_byte,
    // result channel
    output logic                            o_res_valid,
    input  logic                            i_res_stall,
    output logic [tle_pkg::ACT_W-1:0]       o_action,
    output logic [tle_pkg::KEY_W-1:0]       o_echo_char,
    output logic                            o_last_of_run
);

    tle_pkg::t_entry w_front_entry;
    tle_pkg::t_entry w_q_entry;
    logic            w_q_full;
    logic            w_q_valid;
    logic            w_q_pop;

    // front: code registers and classification
    tle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_key_byte  (i_key_byte),
        .o_entry     (w_front_entry)
    );

    // short queue decouples key intake from result sequencing
    tle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_key_valid),
        .i_entry (w_front_entry),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    assign o_key_stall = w_q_full;

    // back: line length, space marks and result sequencer
    tle_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_entry     (w_q_entry),
        .o_q_pop       (w_q_pop),
        .i_res_stall   (i_res_stall),
        .o_res_valid   (o_res_valid),
        .o_action      (o_action),
        .o_echo_char   (o_echo_char),
        .o_last_of_run (o_last_of_run)
    );

    // echoed characters are always printable
    a_echo_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_action == tle_pkg::ACT_ECHO) |->
        (o_echo_char >= tle_pkg::PRINTABLE_LO && o_echo_char <= tle_pkg::PRINTABLE_HI))
        else $error("echo of a non-printable byte");

    // only echo results carry a character
    a_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_action != tle_pkg::ACT_ECHO) |-> (o_echo_char == '0))
        else $error("non-echo result carries a character");

    // a newline always precedes the echo that starts the new line
    a_newline_then_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_action == tle_pkg::ACT_NEWLINE) |-> !o_last_of_run)
        else $error("newline closed a run");

    // end of session is a single-result run
    a_end_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_action == tle_pkg::ACT_END) |-> o_last_of_run)
        else $error("end of session not the last result");

endmodule

FILE: tb/sv/tle_line_checker.sv
`timescale 1ns / 100ps
// tle_line_checker: watches the key, result and config ports of the line editor,
// predicts the screen actions of every key transfer and compares them in order
// depends on tle_pkg
module tle_line_checker #(
    parameter int LINE_CAPACITY = 40
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tle_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tle_pkg::KEY_W-1:0]       i_cfg_data,
    input  logic                            i_key_valid,
    input  logic                            i_key_stall,
    input  logic [tle_pkg::KEY_W-1:0]       i_key_byte,
    input  logic                            i_res_valid,
    input  logic                            i_res_stall,
    input  logic [tle_pkg::ACT_W-1:0]       i_action,
    input  logic [tle_pkg::KEY_W-1:0]       i_echo_char,
    input  logic                            i_last_of_run,
    output logic [31:0]                     o_pending,
    output logic [31:0]                     o_fail_count
);

    localparam int REPORT_CAP = 30;

    typedef struct packed {
        logic [tle_pkg::ACT_W-1:0] action;
        logic [tle_pkg::KEY_W-1:0] echo_char;
        logic                      last_of_run;
    } t_screen_op;

    t_screen_op                screen_q [$];
    logic [tle_pkg::KEY_W-1:0] eof_code;
    logic [tle_pkg::KEY_W-1:0] erase_code;
    logic [tle_pkg::KEY_W-1:0] kill_code;
    logic [tle_pkg::KEY_W-1:0] word_erase_code;
    int                        line_len;
    logic                      space_mark [LINE_CAPACITY];
    logic                      session_over;
    int                        errors = 0;

    initial begin
        o_pending    = '0;
        o_fail_count = '0;
    end

    task automatic emit(input logic [tle_pkg::ACT_W-1:0] act,
                        input logic [tle_pkg::KEY_W-1:0] ch);
        t_screen_op op;
        op.action      = act;
        op.echo_char   = ch;
        op.last_of_run = 1'b0;
        screen_q.push_back(op);
    endtask

    task automatic rub_out;
        line_len--;
        emit(tle_pkg::ACT_RUBOUT, '0);
    endtask

    // screen actions caused by one key, in the priority order of the editor
    task automatic edit_line(input logic [tle_pkg::KEY_W-1:0] key);
        int         first;
        t_screen_op tail;
        first = screen_q.size();
        if (session_over) begin
            return;
        end
        if (key == eof_code && line_len == 0) begin
            session_over = 1'b1;
            emit(tle_pkg::ACT_END, '0);
        end else if (key == erase_code) begin
            if (line_len > 0) rub_out();
        end else if (key == kill_code) begin
            while (line_len > 0) rub_out();
        end else if (key == word_erase_code) begin
            while (line_len > 0 && space_mark[line_len-1]) rub_out();
            while (line_len > 0 && !space_mark[line_len-1]) rub_out();
        end else if (key >= tle_pkg::PRINTABLE_LO && key <= tle_pkg::PRINTABLE_HI) begin
            if (line_len >= LINE_CAPACITY) begin
                emit(tle_pkg::ACT_NEWLINE, '0);
                line_len = 0;
            end
            space_mark[line_len] = (key == tle_pkg::KEY_SPACE);
            line_len++;
            emit(tle_pkg::ACT_ECHO, key);
        end else begin
            emit(tle_pkg::ACT_BELL, '0);
        end
        if (screen_q.size() > first) begin
            tail = screen_q.pop_back();
            tail.last_of_run = 1'b1;
            screen_q.push_back(tail);
        end
    endtask

    task automatic compare_field(input string field, input logic [tle_pkg::KEY_W-1:0] want,
                                 input logic [tle_pkg::KEY_W-1:0] got);
        if (got !== want) begin
            if (errors < REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
            errors++;
        end
    endtask

    task automatic check_result;
        t_screen_op want;
        if (screen_q.size() == 0) begin
            if (errors < REPORT_CAP)
                $display("%0t: result with nothing expected, actual action %0d echo %0d last %0d",
                         $time, i_action, i_echo_char, i_last_of_run);
            errors++;
        end else begin
            want = screen_q.pop_front();
            compare_field("action", tle_pkg::KEY_W'(want.action), tle_pkg::KEY_W'(i_action));
            compare_field("echo_char", want.echo_char, i_echo_char);
            compare_field("last_of_run", tle_pkg::KEY_W'(want.last_of_run),
                          tle_pkg::KEY_W'(i_last_of_run));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            eof_code        = tle_pkg::EOF_RST;
            erase_code      = tle_pkg::ERASE_RST;
            kill_code       = tle_pkg::KILL_RST;
            word_erase_code = tle_pkg::WORD_ERASE_RST;
            line_len        = 0;
            session_over    = 1'b0;
            screen_q.delete();
        end else begin
            // a result never stems from a key taken at the same edge
            if (i_res_valid && !i_res_stall) check_result();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tle_pkg::CFG_EOF:        eof_code = i_cfg_data;
                    tle_pkg::CFG_ERASE:      erase_code = i_cfg_data;
                    tle_pkg::CFG_KILL:       kill_code = i_cfg_data;
                    tle_pkg::CFG_WORD_ERASE: word_erase_code = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_key_valid && !i_key_stall) edit_line(i_key_byte);
        end
        o_pending    <= screen_q.size();
        o_fail_count <= errors;
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// tb: top of the line editor testbench, drives keys, config writes and result stalls
// depends on tle_pkg, terminal_line_editor_core, tle_line_checker
module tb;

    localparam int LINE_CAP  = 40;
    localparam int RUN_LIMIT = 1_000_000;
    // cycles after the last result before the editor counts as idle
    localparam int DRAIN     = 40;
    // one long receiver hold-off so the key queue fills and the editor stalls keys
    localparam int LONG_HOLD = 300;
    localparam int HOLD_AT   = 70;
    localparam int N_OPENING = 23;

    // opening keys under the reset codes, line starts empty:
    //   erase, kill and word erase on an empty line give nothing
    //   control and high bytes ring the bell
    //   end of input on a non-empty line is an ordinary byte (here a bell)
    //   word erase drops two trailing spaces and then the word before them
    localparam logic [tle_pkg::KEY_W-1:0] OPENING [N_OPENING] = '{
        tle_pkg::ERASE_RST, tle_pkg::KILL_RST, tle_pkg::WORD_ERASE_RST, 8'd0, 8'd255,
        8'd128, 8'd31, tle_pkg::KEY_SPACE, tle_pkg::PRINTABLE_HI, tle_pkg::EOF_RST,
        8'd97, tle_pkg::KEY_SPACE, tle_pkg::KEY_SPACE, tle_pkg::WORD_ERASE_RST,
        tle_pkg::ERASE_RST, 8'd104, 8'd105, tle_pkg::KEY_SPACE, 8'd120,
        tle_pkg::KILL_RST, 8'd122, tle_pkg::ERASE_RST, 8'd160
    };

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [tle_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [tle_pkg::KEY_W-1:0]     i_cfg_data  = '0;
    logic                          i_key_valid = 1'b0;
    logic [tle_pkg::KEY_W-1:0]     i_key_byte  = '0;
    logic                          i_res_stall = 1'b0;
    logic                          o_key_stall;
    logic                          o_res_valid;
    logic [tle_pkg::ACT_W-1:0]     o_action;
    logic [tle_pkg::KEY_W-1:0]     o_echo_char;
    logic                          o_last_of_run;
    logic [31:0]                   pending;
    logic [31:0]                   fail_count;
    int                            cycle_count = 0;

    // codes as last written, only used to steer the stimulus
    logic [tle_pkg::KEY_W-1:0]     code_of [4];
    // set while the last key surely left text on the line, so the end-of-input
    // code cannot close the session before the end of the run
    logic                          line_has_text = 1'b0;
    // sender runs without gaps while set
    logic                          key_burst = 1'b1;

    terminal_line_editor_core #(
        .LINE_CAPACITY (LINE_CAP)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_key_valid   (i_key_valid),
        .o_key_stall   (o_key_stall),
        .i_key_byte    (i_key_byte),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_action      (o_action),
        .o_echo_char   (o_echo_char),
        .o_last_of_run (o_last_of_run)
    );

    tle_line_checker #(
        .LINE_CAPACITY (LINE_CAP)
    ) line_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_key_valid   (i_key_valid),
        .i_key_stall   (o_key_stall),
        .i_key_byte    (i_key_byte),
        .i_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .i_action      (o_action),
        .i_echo_char   (o_echo_char),
        .i_last_of_run (o_last_of_run),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    // result side: a random hold-off before each transfer, stretches without any,
    // and one long hold-off while keys keep coming
    initial begin : result_sink
        int   gap;
        int   taken;
        logic steady;
        taken  = 0;
        steady = 1'b0;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0) steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 10);
            if (taken == HOLD_AT) gap = LONG_HOLD;
            if (gap > 0) begin
                i_res_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_res_stall <= 1'b0;
            do @(posedge i_clk); while (o_res_valid !== 1'b1);
            taken++;
        end
    end

    // one key transfer after a random gap; valid stays high into the next call
    // so it is never dropped and raised at the same edge
    task automatic offer_key(input logic [tle_pkg::KEY_W-1:0] k);
        int gap;
        if ($urandom_range(0, 15) == 0) key_burst = !key_burst;
        gap = key_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_key_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_key_valid <= 1'b1;
        i_key_byte  <= k;
        do @(posedge i_clk); while (o_key_stall);
    endtask

    // like offer_key, but keeps the session open: the end-of-input code is only
    // sent while the line surely holds text
    task automatic type_key(input logic [tle_pkg::KEY_W-1:0] k);
        while (k == code_of[tle_pkg::CFG_EOF] && !line_has_text) k = $urandom_range(0, 255);
        offer_key(k);
        line_has_text = k >= tle_pkg::PRINTABLE_LO && k <= tle_pkg::PRINTABLE_HI
            && k != code_of[tle_pkg::CFG_ERASE] && k != code_of[tle_pkg::CFG_KILL]
            && k != code_of[tle_pkg::CFG_WORD_ERASE]
            && (k != code_of[tle_pkg::CFG_EOF] || line_has_text);
    endtask

    // sender pauses until every expected result has come and the editor is idle
    task automatic settle;
        i_key_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // writes all four codes on back-to-back edges, only while idle
    task automatic program_codes(input logic [tle_pkg::KEY_W-1:0] eof_c,
                                 input logic [tle_pkg::KEY_W-1:0] erase_c,
                                 input logic [tle_pkg::KEY_W-1:0] kill_c,
                                 input logic [tle_pkg::KEY_W-1:0] word_c);
        code_of[tle_pkg::CFG_EOF]        = eof_c;
        code_of[tle_pkg::CFG_ERASE]      = erase_c;
        code_of[tle_pkg::CFG_KILL]       = kill_c;
        code_of[tle_pkg::CFG_WORD_ERASE] = word_c;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tle_pkg::CFG_EOF;
        i_cfg_data  <= eof_c;
        @(posedge i_clk);
        i_cfg_index <= tle_pkg::CFG_ERASE;
        i_cfg_data  <= erase_c;
        @(posedge i_clk);
        i_cfg_index <= tle_pkg::CFG_KILL;
        i_cfg_data  <= kill_c;
        @(posedge i_clk);
        i_cfg_index <= tle_pkg::CFG_WORD_ERASE;
        i_cfg_data  <= word_c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random editing session: runs of words with spaces, erase, kill, word erase,
    // noise bytes, end of input on a non-empty line and idle pauses; with
    // fill_line it first empties the line, types a full line of letters and
    // then sends closer (a letter wraps the line, a code clears 40 characters)
    task automatic random_phase(input int n_items, input logic fill_line,
                                input logic [tle_pkg::KEY_W-1:0] closer);
        int                        sent;
        int                        kind;
        int                        len;
        logic [tle_pkg::KEY_W-1:0] k;
        sent = 0;
        if (fill_line) begin
            type_key(code_of[tle_pkg::CFG_KILL]);
            repeat (LINE_CAP) begin
                k = $urandom_range(97, 122);
                type_key(k);
            end
            type_key(closer);
            sent = LINE_CAP + 2;
        end
        while (sent < n_items) begin
            kind = $urandom_range(0, 11);
            len  = 1;
            case (kind)
                0, 1, 2, 3, 4: begin
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 46)
                                                     : $urandom_range(1, 12);
                    repeat (len) begin
                        k = $urandom_range(33, 126);
                        if ($urandom_range(0, 3) == 0) k = tle_pkg::KEY_SPACE;
                        type_key(k);
                    end
                end
                5: begin
                    len = $urandom_range(1, 3);
                    repeat (len) type_key(code_of[tle_pkg::CFG_ERASE]);
                end
                6: type_key(code_of[tle_pkg::CFG_KILL]);
                7, 8: begin
                    len = $urandom_range(1, 2);
                    repeat (len) type_key(code_of[tle_pkg::CFG_WORD_ERASE]);
                end
                9: begin
                    len = $urandom_range(1, 3);
                    repeat (len) begin
                        k = $urandom_range(0, 255);
                        type_key(k);
                    end
                end
                10: begin
                    k = $urandom_range(0, 255);
                    type_key(line_has_text ? code_of[tle_pkg::CFG_EOF] : k);
                end
                default: begin
                    len = 0;
                    settle();
                end
            endcase
            sent += len;
        end
    endtask

    initial begin : stimulus
        code_of[tle_pkg::CFG_EOF]        = tle_pkg::EOF_RST;
        code_of[tle_pkg::CFG_ERASE]      = tle_pkg::ERASE_RST;
        code_of[tle_pkg::CFG_KILL]       = tle_pkg::KILL_RST;
        code_of[tle_pkg::CFG_WORD_ERASE] = tle_pkg::WORD_ERASE_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed opening under the reset codes
        for (int n = 0; n < N_OPENING; n++) type_key(OPENING[n]);
        settle();

        // extreme and high codes; full line then one more letter wraps it
        program_codes(8'd0, 8'd255, 8'd128, 8'd200);
        random_phase(46, 1'b1, 8'd97);
        settle();

        // coinciding codes: end of input wins over erase only on an empty line,
        // kill beats word erase, and the space itself kills
        program_codes(8'd8, 8'd8, tle_pkg::KEY_SPACE, tle_pkg::KEY_SPACE);
        random_phase(45, 1'b0, 8'd0);
        settle();

        // codes near the edges of the printable range, inside and outside it
        program_codes(tle_pkg::PRINTABLE_HI, 8'd33, 8'd127, 8'd31);
        random_phase(45, 1'b0, 8'd0);
        settle();

        // back to the reset codes; full line cleared by kill
        program_codes(tle_pkg::EOF_RST, tle_pkg::ERASE_RST, tle_pkg::KILL_RST,
                      tle_pkg::WORD_ERASE_RST);
        random_phase(46, 1'b1, tle_pkg::KILL_RST);

        // close the session on an empty line, then keys that must be dropped
        offer_key(tle_pkg::KILL_RST);
        offer_key(tle_pkg::EOF_RST);
        offer_key(8'd97);
        offer_key(tle_pkg::ERASE_RST);
        offer_key(8'd0);
        offer_key(8'd255);
        settle();

        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
